// ===== hw/rtl/tfr_pkg.sv =====
// Shared types, constants and helpers for the triangle tangent frame block.
package tfr_pkg;

  localparam int VW = 36;
  localparam int NORM_STEPS = 30;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 15;
  localparam int MUL_STEPS = 10;
  localparam int VEC_STEPS = 3;

  localparam logic [15:0] FALLBACK_X_LIMIT = 16'd14745;
  localparam logic [1:0] LAST_CORNER = 2'd2;

  localparam logic CFG_DET_FLOOR = 1'b0;
  localparam logic CFG_TANGENT_FLOOR = 1'b1;

  typedef logic signed [15:0] comp_t;
  typedef logic signed [16:0] diff_t;
  typedef logic signed [VW-1:0] wide_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_NORM,
    U_SQ,
    U_SQRT,
    U_DIV
  } unit_state_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SEL,
    F_UNIT,
    F_HOLD
  } front_state_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_DOT,
    L_SUB,
    L_SQ,
    L_SEL,
    L_UNIT,
    L_CR,
    L_HD
  } lane_state_t;

  typedef struct packed {
    logic [47:0] tan;
    logic [47:0] bitan;
    logic [47:0] face;
    logic [47:0] nrm_a;
    logic [47:0] nrm_b;
    logic [47:0] nrm_c;
    logic        nrm_valid;
  } frame_t;

  function automatic comp_t lane_of(input logic [47:0] w, input int unsigned i);
    lane_of = w[16*i +: 16];
  endfunction

endpackage

// ===== hw/rtl/tfr_unitize.sv =====
// Iterative vector normalizer: scale, sum of squares, square root, divide.
module tfr_unitize (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tfr_pkg::wide_t      vec_i [3],
  output logic                done,
  output logic [47:0]         unit_o
);

  tfr_pkg::unit_state_t state_r, state_nxt;
  logic [4:0]  cnt_r;
  logic        done_r;
  logic [35:0] mg_r [3];
  logic [2:0]  neg_r;
  logic        zero_r;
  logic [61:0] sum_r;
  logic [62:0] x_r, res_r, bit_r;
  logic [46:0] dvs_r;
  logic [46:0] rem_r [3];
  logic [14:0] q_r [3];
  logic [47:0] unit_r;

  logic        shr, shl;
  logic [29:0] mk;
  logic [59:0] sq_term;
  logic [62:0] t_sum, res_next, x_next;
  logic        ge;
  logic [2:0]  dge;
  logic [14:0] qf [3];
  logic        last_norm, last_sq, last_sqrt, last_div;

  always_comb begin
    shr = |{mg_r[0][35:30], mg_r[1][35:30], mg_r[2][35:30]};
    shl = !shr && !(mg_r[0][29] || mg_r[1][29] || mg_r[2][29]) && !zero_r;
    mk = mg_r[cnt_r[1:0]][29:0];
    sq_term = mk * mk;
    t_sum = res_r + bit_r;
    ge = x_r >= t_sum;
    res_next = ge ? (res_r >> 1) + bit_r : res_r >> 1;
    x_next = ge ? x_r - t_sum : x_r;
    for (int i = 0; i < 3; i++) begin
      dge[i] = rem_r[i] >= dvs_r;
      qf[i] = {q_r[i][13:0], dge[i]};
    end
    last_norm = cnt_r == 5'(tfr_pkg::NORM_STEPS - 1);
    last_sq = cnt_r == 5'(tfr_pkg::VEC_STEPS - 1);
    last_sqrt = cnt_r == 5'(tfr_pkg::SQRT_STEPS - 1);
    last_div = cnt_r == 5'(tfr_pkg::DIV_STEPS - 1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfr_pkg::U_IDLE: if (start) state_nxt = tfr_pkg::U_NORM;
      tfr_pkg::U_NORM: if (last_norm) state_nxt = tfr_pkg::U_SQ;
      tfr_pkg::U_SQ:   if (last_sq) state_nxt = tfr_pkg::U_SQRT;
      tfr_pkg::U_SQRT: if (last_sqrt) state_nxt = tfr_pkg::U_DIV;
      tfr_pkg::U_DIV:  if (last_div) state_nxt = tfr_pkg::U_IDLE;
      default:         state_nxt = tfr_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfr_pkg::U_IDLE;
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= (state_nxt != state_r) ? '0 : cnt_r + 5'd1;
      done_r <= (state_r == tfr_pkg::U_DIV) && last_div;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tfr_pkg::U_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vec_i[i][35];
            mg_r[i] <= vec_i[i][35] ? -vec_i[i] : vec_i[i];
          end
          zero_r <= (vec_i[0] == '0) && (vec_i[1] == '0) && (vec_i[2] == '0);
          sum_r <= '0;
        end
      end
      tfr_pkg::U_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (shr) mg_r[i] <= mg_r[i] >> 1;
          else if (shl) mg_r[i] <= mg_r[i] << 1;
        end
      end
      tfr_pkg::U_SQ: begin
        sum_r <= sum_r + sq_term;
        if (last_sq) begin
          x_r <= sum_r + sq_term;
          res_r <= '0;
          bit_r <= {1'b1, 62'b0};
        end
      end
      tfr_pkg::U_SQRT: begin
        x_r <= x_next;
        res_r <= res_next;
        bit_r <= bit_r >> 2;
        if (last_sqrt) begin
          dvs_r <= {1'b0, res_next[31:0], 14'b0};
          for (int i = 0; i < 3; i++) begin
            rem_r[i] <= {3'b0, mg_r[i][29:0], 14'b0} + {16'b0, res_next[31:1]};
            q_r[i] <= '0;
          end
        end
      end
      tfr_pkg::U_DIV: begin
        dvs_r <= dvs_r >> 1;
        for (int i = 0; i < 3; i++) begin
          if (dge[i]) rem_r[i] <= rem_r[i] - dvs_r;
          q_r[i] <= qf[i];
          if (last_div) begin
            unit_r[16*i +: 16] <= zero_r ? 16'd0 :
                                  (neg_r[i] ? -{1'b0, qf[i]} : {1'b0, qf[i]});
          end
        end
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign unit_o = unit_r;

endmodule

// ===== hw/rtl/tfr_front.sv =====
// Triangle setup: edge and UV deltas, frame numerators, face normal, normalize.
module tfr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      det_floor,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [47:0]      in_pos_a,
  input  logic [47:0]      in_pos_b,
  input  logic [47:0]      in_pos_c,
  input  logic             in_uv_valid,
  input  logic [31:0]      in_uv_a,
  input  logic [31:0]      in_uv_b,
  input  logic [31:0]      in_uv_c,
  input  logic             in_normals_valid,
  input  logic [47:0]      in_normal_a,
  input  logic [47:0]      in_normal_b,
  input  logic [47:0]      in_normal_c,
  output logic             fr_valid,
  input  logic             fr_take,
  output tfr_pkg::frame_t  frame
);

  tfr_pkg::front_state_t state_r, state_nxt;
  logic [3:0]     step_r;
  tfr_pkg::diff_t e1_r [3];
  tfr_pkg::diff_t e2_r [3];
  tfr_pkg::diff_t du1_r, dv1_r, du2_r, dv2_r;
  logic           uvv_r, nv_r;
  logic [47:0]    nrm_a_r, nrm_b_r, nrm_c_r;
  tfr_pkg::wide_t raw_r [tfr_pkg::MUL_STEPS];

  tfr_pkg::diff_t ma, mb, mc, md;
  tfr_pkg::wide_t pa, pb, prod;
  logic           det_neg, use_uv;
  logic [35:0]    det_mag;
  tfr_pkg::wide_t tn_vec [3];
  tfr_pkg::wide_t bn_vec [3];
  tfr_pkg::wide_t fn_vec [3];
  logic [2:0]     u_done;
  logic [47:0]    tan_u, bit_u, face_u;
  logic           last_mul;

  always_comb begin
    ma = '0; mb = '0; mc = '0; md = '0;
    case (step_r)
      4'd0: begin ma = du1_r; mb = dv2_r; mc = du2_r; md = dv1_r; end
      4'd1: begin ma = e1_r[0]; mb = dv2_r; mc = e2_r[0]; md = dv1_r; end
      4'd2: begin ma = e1_r[1]; mb = dv2_r; mc = e2_r[1]; md = dv1_r; end
      4'd3: begin ma = e1_r[2]; mb = dv2_r; mc = e2_r[2]; md = dv1_r; end
      4'd4: begin ma = e2_r[0]; mb = du1_r; mc = e1_r[0]; md = du2_r; end
      4'd5: begin ma = e2_r[1]; mb = du1_r; mc = e1_r[1]; md = du2_r; end
      4'd6: begin ma = e2_r[2]; mb = du1_r; mc = e1_r[2]; md = du2_r; end
      4'd7: begin ma = e1_r[1]; mb = e2_r[2]; mc = e1_r[2]; md = e2_r[1]; end
      4'd8: begin ma = e1_r[2]; mb = e2_r[0]; mc = e1_r[0]; md = e2_r[2]; end
      4'd9: begin ma = e1_r[0]; mb = e2_r[1]; mc = e1_r[1]; md = e2_r[0]; end
      default: ;
    endcase
    pa = ma * mb;
    pb = mc * md;
    prod = pa - pb;
    last_mul = step_r == 4'(tfr_pkg::MUL_STEPS - 1);
  end

  always_comb begin
    det_neg = raw_r[0][35];
    det_mag = det_neg ? -raw_r[0] : raw_r[0];
    use_uv = uvv_r && (det_mag > {20'b0, det_floor});
    for (int i = 0; i < 3; i++) begin
      if (use_uv) begin
        tn_vec[i] = det_neg ? -raw_r[1+i] : raw_r[1+i];
        bn_vec[i] = det_neg ? -raw_r[4+i] : raw_r[4+i];
      end else begin
        tn_vec[i] = e1_r[i];
        bn_vec[i] = '0;
      end
      fn_vec[i] = raw_r[7+i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall = state_r != tfr_pkg::F_IDLE;
    fr_valid = state_r == tfr_pkg::F_HOLD;
    unique case (state_r)
      tfr_pkg::F_IDLE: if (in_valid) state_nxt = tfr_pkg::F_MUL;
      tfr_pkg::F_MUL:  if (last_mul) state_nxt = tfr_pkg::F_SEL;
      tfr_pkg::F_SEL:  state_nxt = tfr_pkg::F_UNIT;
      tfr_pkg::F_UNIT: if (&u_done) state_nxt = tfr_pkg::F_HOLD;
      tfr_pkg::F_HOLD: if (fr_take) state_nxt = tfr_pkg::F_IDLE;
      default:         state_nxt = tfr_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfr_pkg::F_IDLE;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= (state_r == tfr_pkg::F_MUL) ? step_r + 4'd1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tfr_pkg::F_IDLE && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= tfr_pkg::lane_of(in_pos_b, i) - tfr_pkg::lane_of(in_pos_a, i);
        e2_r[i] <= tfr_pkg::lane_of(in_pos_c, i) - tfr_pkg::lane_of(in_pos_a, i);
      end
      du1_r <= tfr_pkg::lane_of(48'(in_uv_b), 0) - tfr_pkg::lane_of(48'(in_uv_a), 0);
      dv1_r <= tfr_pkg::lane_of(48'(in_uv_b), 1) - tfr_pkg::lane_of(48'(in_uv_a), 1);
      du2_r <= tfr_pkg::lane_of(48'(in_uv_c), 0) - tfr_pkg::lane_of(48'(in_uv_a), 0);
      dv2_r <= tfr_pkg::lane_of(48'(in_uv_c), 1) - tfr_pkg::lane_of(48'(in_uv_a), 1);
      uvv_r <= in_uv_valid;
      nv_r <= in_normals_valid;
      nrm_a_r <= in_normal_a;
      nrm_b_r <= in_normal_b;
      nrm_c_r <= in_normal_c;
    end
    if (state_r == tfr_pkg::F_MUL) raw_r[step_r] <= prod;
  end

  tfr_unitize u_tan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == tfr_pkg::F_SEL),
    .vec_i  (tn_vec),
    .done   (u_done[0]),
    .unit_o (tan_u)
  );

  tfr_unitize u_bit (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == tfr_pkg::F_SEL),
    .vec_i  (bn_vec),
    .done   (u_done[1]),
    .unit_o (bit_u)
  );

  tfr_unitize u_face (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == tfr_pkg::F_SEL),
    .vec_i  (fn_vec),
    .done   (u_done[2]),
    .unit_o (face_u)
  );

  always_comb begin
    frame.tan = tan_u;
    frame.bitan = bit_u;
    frame.face = face_u;
    frame.nrm_a = nrm_a_r;
    frame.nrm_b = nrm_b_r;
    frame.nrm_c = nrm_c_r;
    frame.nrm_valid = nv_r;
  end

endmodule

// ===== hw/rtl/tfr_lane.sv =====
// One corner lane: orthogonalize, axis fallback, normalize, handedness.
module tfr_lane (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] tangent_floor,
  input  logic [47:0] tu,
  input  logic [47:0] bu,
  input  logic [47:0] nrm,
  output logic        done,
  output logic [47:0] tq_o,
  output logic        flipped_o
);

  tfr_pkg::lane_state_t state_r, state_nxt;
  logic [1:0]          k_r;
  tfr_pkg::comp_t      tu_r [3];
  tfr_pkg::comp_t      bu_r [3];
  tfr_pkg::comp_t      n_r [3];
  logic signed [33:0]  d_r;
  logic [31:0]         tf2_r;
  logic signed [23:0]  tj_r [3];
  logic [49:0]         sq_r;
  logic signed [32:0]  cr_r [3];
  logic signed [50:0]  hd_r;
  logic                flip_r, done_r;

  logic signed [33:0]  dprod;
  logic signed [49:0]  p;
  logic [49:0]         pm, pr;
  logic [21:0]         rv;
  logic signed [23:0]  tu_ext, rs_s;
  logic signed [49:0]  sqt;
  logic                fb;
  logic [15:0]         n0_mag;
  tfr_pkg::wide_t      uvec [3];
  logic                u_done;
  logic [47:0]         u_out;
  tfr_pkg::comp_t      tq [3];
  tfr_pkg::comp_t      ca, cb, cc, cd;
  logic signed [32:0]  cpa, cpb;
  logic signed [50:0]  hp, hd_sum;
  logic                last_k;

  always_comb begin
    for (int i = 0; i < 3; i++) tq[i] = tfr_pkg::lane_of(u_out, i);
    last_k = k_r == 2'(tfr_pkg::VEC_STEPS - 1);
    dprod = n_r[k_r] * tu_r[k_r];
    p = n_r[k_r] * d_r;
    pm = p[49] ? -p : p;
    pr = pm + {22'b0, 1'b1, 27'b0};
    rv = pr[49:28];
    rs_s = {2'b00, rv};
    if (p[49]) rs_s = -rs_s;
    tu_ext = tu_r[k_r];
    sqt = tj_r[k_r] * tj_r[k_r];
    fb = sq_r <= {18'b0, tf2_r};
    n0_mag = n_r[0][15] ? -n_r[0] : n_r[0];
    if (!fb) begin
      for (int i = 0; i < 3; i++) uvec[i] = tj_r[i];
    end else if (n0_mag <= tfr_pkg::FALLBACK_X_LIMIT) begin
      uvec[0] = '0;
      uvec[1] = n_r[2];
      uvec[2] = -tfr_pkg::wide_t'(n_r[1]);
    end else begin
      uvec[0] = -tfr_pkg::wide_t'(n_r[2]);
      uvec[1] = '0;
      uvec[2] = n_r[0];
    end
    ca = '0; cb = '0; cc = '0; cd = '0;
    case (k_r)
      2'd0: begin ca = n_r[1]; cb = tq[2]; cc = n_r[2]; cd = tq[1]; end
      2'd1: begin ca = n_r[2]; cb = tq[0]; cc = n_r[0]; cd = tq[2]; end
      2'd2: begin ca = n_r[0]; cb = tq[1]; cc = n_r[1]; cd = tq[0]; end
      default: ;
    endcase
    cpa = ca * cb;
    cpb = cc * cd;
    hp = cr_r[k_r] * bu_r[k_r];
    hd_sum = hd_r + hp;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfr_pkg::L_IDLE: if (start) state_nxt = tfr_pkg::L_DOT;
      tfr_pkg::L_DOT:  if (last_k) state_nxt = tfr_pkg::L_SUB;
      tfr_pkg::L_SUB:  if (last_k) state_nxt = tfr_pkg::L_SQ;
      tfr_pkg::L_SQ:   if (last_k) state_nxt = tfr_pkg::L_SEL;
      tfr_pkg::L_SEL:  state_nxt = tfr_pkg::L_UNIT;
      tfr_pkg::L_UNIT: if (u_done) state_nxt = tfr_pkg::L_CR;
      tfr_pkg::L_CR:   if (last_k) state_nxt = tfr_pkg::L_HD;
      tfr_pkg::L_HD:   if (last_k) state_nxt = tfr_pkg::L_IDLE;
      default:         state_nxt = tfr_pkg::L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfr_pkg::L_IDLE;
      k_r <= '0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r <= (state_nxt != state_r) ? '0 : k_r + 2'd1;
      done_r <= (state_r == tfr_pkg::L_HD) && last_k;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tfr_pkg::L_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            tu_r[i] <= tfr_pkg::lane_of(tu, i);
            bu_r[i] <= tfr_pkg::lane_of(bu, i);
            n_r[i] <= tfr_pkg::lane_of(nrm, i);
          end
          d_r <= '0;
          sq_r <= '0;
          hd_r <= '0;
          tf2_r <= tangent_floor * tangent_floor;
        end
      end
      tfr_pkg::L_DOT: d_r <= d_r + dprod;
      tfr_pkg::L_SUB: tj_r[k_r] <= tu_ext - rs_s;
      tfr_pkg::L_SQ:  sq_r <= sq_r + sqt;
      tfr_pkg::L_CR:  cr_r[k_r] <= cpa - cpb;
      tfr_pkg::L_HD: begin
        hd_r <= hd_sum;
        if (last_k) flip_r <= hd_sum[50];
      end
      default: ;
    endcase
  end

  tfr_unitize u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == tfr_pkg::L_SEL),
    .vec_i  (uvec),
    .done   (u_done),
    .unit_o (u_out)
  );

  assign done = done_r;
  assign tq_o = u_out;
  assign flipped_o = flip_r;

endmodule

// ===== hw/rtl/triangle_tangent_frame.sv =====
// Triangle tangent frame top level: config registers, setup, corner lanes, result merge.
// One triangle request yields three corner results (corners 0, 1, 2; last on corner 2).
// The setup stage takes a triangle through 10 multiply steps, then normalizes the
// tangent, bitangent and face normal side by side; three corner lanes then run
// together, bound by their own normalize unit (30 scaling steps, 3 squaring steps,
// 32 square-root steps, 15 divide steps). Setup and lanes overlap, but the lanes
// restart only after the merge buffer has drained, so the setup stage takes a new
// triangle only after the lanes have taken the frame of the one before.
// The merge buffer then drains one corner per cycle while out_stall is low.
module triangle_tangent_frame (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] in_pos_a,
  input  logic [47:0] in_pos_b,
  input  logic [47:0] in_pos_c,
  input  logic        in_uv_valid,
  input  logic [31:0] in_uv_a,
  input  logic [31:0] in_uv_b,
  input  logic [31:0] in_uv_c,
  input  logic        in_normals_valid,
  input  logic [47:0] in_normal_a,
  input  logic [47:0] in_normal_b,
  input  logic [47:0] in_normal_c,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_tangent,
  output logic        out_flipped,
  output logic [1:0]  out_corner,
  output logic        out_last
);

  logic [15:0]     det_floor_r, tangent_floor_r;
  logic            fr_valid, lane_start;
  tfr_pkg::frame_t frame;
  logic [47:0]     lane_nrm [3];
  logic [2:0]      lane_done;
  logic [47:0]     lane_tq [3];
  logic [2:0]      lane_flip;
  logic            lane_busy_r, buf_full_r;
  logic [1:0]      idx_r;
  logic [47:0]     buf_tan_r [3];
  logic [2:0]      buf_flip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_floor_r <= '0;
      tangent_floor_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfr_pkg::CFG_DET_FLOOR:     det_floor_r <= cfg_data;
        tfr_pkg::CFG_TANGENT_FLOOR: tangent_floor_r <= cfg_data;
      endcase
    end
  end

  tfr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .det_floor        (det_floor_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pos_a         (in_pos_a),
    .in_pos_b         (in_pos_b),
    .in_pos_c         (in_pos_c),
    .in_uv_valid      (in_uv_valid),
    .in_uv_a          (in_uv_a),
    .in_uv_b          (in_uv_b),
    .in_uv_c          (in_uv_c),
    .in_normals_valid (in_normals_valid),
    .in_normal_a      (in_normal_a),
    .in_normal_b      (in_normal_b),
    .in_normal_c      (in_normal_c),
    .fr_valid         (fr_valid),
    .fr_take          (lane_start),
    .frame            (frame)
  );

  assign lane_start = fr_valid && !lane_busy_r && !buf_full_r;

  always_comb begin
    lane_nrm[0] = frame.nrm_valid ? frame.nrm_a : frame.face;
    lane_nrm[1] = frame.nrm_valid ? frame.nrm_b : frame.face;
    lane_nrm[2] = frame.nrm_valid ? frame.nrm_c : frame.face;
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    tfr_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .start         (lane_start),
      .tangent_floor (tangent_floor_r),
      .tu            (frame.tan),
      .bu            (frame.bitan),
      .nrm           (lane_nrm[j]),
      .done          (lane_done[j]),
      .tq_o          (lane_tq[j]),
      .flipped_o     (lane_flip[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_busy_r <= 1'b0;
      buf_full_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (lane_start) lane_busy_r <= 1'b1;
      if (&lane_done) begin
        lane_busy_r <= 1'b0;
        buf_full_r <= 1'b1;
        idx_r <= '0;
      end else if (buf_full_r && !out_stall) begin
        if (idx_r == tfr_pkg::LAST_CORNER) buf_full_r <= 1'b0;
        else idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (&lane_done) begin
      for (int i = 0; i < 3; i++) buf_tan_r[i] <= lane_tq[i];
      buf_flip_r <= lane_flip;
    end
  end

  assign out_valid = buf_full_r;
  assign out_tangent = buf_tan_r[idx_r];
  assign out_flipped = buf_flip_r[idx_r];
  assign out_corner = idx_r;
  assign out_last = idx_r == tfr_pkg::LAST_CORNER;

endmodule
